[rtl/x86_16bit_alu_register_execute_unit_defines.svh]
// assertion macros shared by the checker of the x86 alu execute unit
// no dependencies; included by files that carry concurrent assertions
`ifndef X86_16BIT_ALU_REGISTER_EXECUTE_UNIT_DEFINES_SVH
`define X86_16BIT_ALU_REGISTER_EXECUTE_UNIT_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define X86ALU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("x86alu: assertion failed");

// same, with a message of its own
`define X86ALU_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

[rtl/x86alu_pkg.sv]
// types, constants and helper functions of the x86 alu execute unit
// no dependencies; used by the top level and by the testbench
package x86alu_pkg;

  // register file geometry
  localparam int unsigned RegWidth = 16;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;

  // instruction kinds
  typedef enum logic [3:0] {
    KIND_ADD = 4'd0,
    KIND_OR  = 4'd1,
    KIND_ADC = 4'd2,
    KIND_SBB = 4'd3,
    KIND_AND = 4'd4,
    KIND_SUB = 4'd5,
    KIND_XOR = 4'd6,
    KIND_CMP = 4'd7,
    KIND_MOV = 4'd8
  } kind_e;

  // flag positions in the flags word
  localparam int unsigned FlagCfBit = 0;
  localparam int unsigned FlagPfBit = 2;
  localparam int unsigned FlagAfBit = 4;
  localparam int unsigned FlagZfBit = 6;
  localparam int unsigned FlagSfBit = 7;
  localparam int unsigned FlagOfBit = 11;

  typedef struct packed {
    logic of_f;
    logic sf;
    logic zf;
    logic af;
    logic pf;
    logic cf;
  } flags_t;

  // pack the status flags into the architectural flags word
  function automatic logic [RegWidth-1:0] flags_to_word(flags_t f);
    logic [RegWidth-1:0] w;
    w            = '0;
    w[FlagCfBit] = f.cf;
    w[FlagPfBit] = f.pf;
    w[FlagAfBit] = f.af;
    w[FlagZfBit] = f.zf;
    w[FlagSfBit] = f.sf;
    w[FlagOfBit] = f.of_f;
    return w;
  endfunction

  // register file entry addressed by a register code; byte codes 4-7 map to 0-3
  function automatic logic [RegIdxW-1:0] reg_index(logic [RegIdxW-1:0] code, logic word);
    return word ? code : {1'b0, code[RegIdxW-2:0]};
  endfunction

  // operand view of an entry: whole word, or low/high byte zero-extended
  function automatic logic [RegWidth-1:0] reg_view(logic [RegWidth-1:0] ent,
                                                   logic [RegIdxW-1:0] code, logic word);
    logic [RegWidth-1:0] v;
    if (word) begin
      v = ent;
    end else if (code[RegIdxW-1]) begin
      v = {8'h00, ent[15:8]};
    end else begin
      v = {8'h00, ent[7:0]};
    end
    return v;
  endfunction

  // merge a result into an entry at the width and half given by the code
  function automatic logic [RegWidth-1:0] reg_merge(logic [RegWidth-1:0] ent,
                                                    logic [RegWidth-1:0] val,
                                                    logic [RegIdxW-1:0] code, logic word);
    logic [RegWidth-1:0] m;
    if (word) begin
      m = val;
    end else if (code[RegIdxW-1]) begin
      m = {val[7:0], ent[7:0]};
    end else begin
      m = {ent[15:8], val[7:0]};
    end
    return m;
  endfunction

endpackage

[rtl/x86alu_ram.sv]
// generic ram: one write port, two read ports with registered read data
// depends on nothing; the depth sets the address width
module x86alu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

[rtl/x86_16bit_alu_register_execute_unit.sv]
// Executes one 16-bit x86-style register/immediate ALU instruction per request and
// returns the old and new destination value with the flags word. A request is taken
// every cycle while the result side keeps up; a result passes through the register
// file read, then execute into the output register, before it appears.
// The register file sits in a two-read-port RAM read in the accept cycle; a one-entry
// write-back bypass covers a request that uses the register written by the one
// just ahead of it, so dependent instructions also run back to back. Per-entry valid
// bits make the register file read as zero after reset, with no clearing pass.
// stall_o rises only while a finished result is held by stall_i and another request
// already waits in the execute stage.
// depends on x86alu_pkg and x86alu_ram
module x86_16bit_alu_register_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [3:0]  kind_i,
  input  logic        word_size_i,
  input  logic [2:0]  dest_reg_i,
  input  logic        src_is_imm_i,
  input  logic [2:0]  src_reg_i,
  input  logic [15:0] immediate_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] dest_before_o,
  output logic [15:0] dest_after_o,
  output logic [15:0] flag_word_o
);

  localparam int unsigned W  = x86alu_pkg::RegWidth;
  localparam int unsigned IW = x86alu_pkg::RegIdxW;

  // handshake and stage control
  logic accept, advance, retire;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  assign advance = !out_valid_q || !stall_i;
  assign stall_o = s1_valid_q && !advance;
  assign accept  = valid_i && !stall_o;
  assign retire  = s1_valid_q && advance;

  // execute stage request registers
  logic [3:0]    s1_kind_q;
  logic          s1_word_q;
  logic [IW-1:0] s1_dest_q;
  logic          s1_src_imm_q;
  logic [IW-1:0] s1_src_q;
  logic [W-1:0]  s1_imm_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q    <= kind_i;
      s1_word_q    <= word_size_i;
      s1_dest_q    <= dest_reg_i;
      s1_src_imm_q <= src_is_imm_i;
      s1_src_q     <= src_reg_i;
      s1_imm_q     <= immediate_i;
    end
  end

  // register file ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [W-1:0]  rd_dest, rd_src;

  x86alu_ram #(
    .Width (x86alu_pkg::RegWidth),
    .Depth (x86alu_pkg::NumRegs)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (accept),
    .raddr_a_i (x86alu_pkg::reg_index(dest_reg_i, word_size_i)),
    .raddr_b_i (x86alu_pkg::reg_index(src_reg_i, word_size_i)),
    .rdata_a_o (rd_dest),
    .rdata_b_o (rd_src)
  );

  // entry valid bits, last write-back for the bypass, flags
  logic [x86alu_pkg::NumRegs-1:0] ent_valid_q;
  logic                           wb_valid_q;
  logic [IW-1:0]                  wb_idx_q;
  logic [W-1:0]                   wb_data_q;
  x86alu_pkg::flags_t             flags_q, flags_d;
  logic                           flags_upd;

  // operand fetch with bypass of the write made in the accept cycle
  logic [IW-1:0] dest_idx, src_idx;
  logic [W-1:0]  dest_ent, src_ent;

  always_comb begin
    dest_idx = x86alu_pkg::reg_index(s1_dest_q, s1_word_q);
    src_idx  = x86alu_pkg::reg_index(s1_src_q, s1_word_q);
    if (wb_valid_q && (wb_idx_q == dest_idx)) begin
      dest_ent = wb_data_q;
    end else begin
      dest_ent = ent_valid_q[dest_idx] ? rd_dest : '0;
    end
    if (wb_valid_q && (wb_idx_q == src_idx)) begin
      src_ent = wb_data_q;
    end else begin
      src_ent = ent_valid_q[src_idx] ? rd_src : '0;
    end
  end

  // alu and flag logic
  logic [W-1:0] l_op, s_op, t_res, new_val, x_bits;
  logic [W:0]   r_res, sum_res, diff_res;
  logic         is_add, is_sub, use_cin, cin, do_write, msb_sel;
  logic         of_add, of_sub;

  always_comb begin
    l_op = x86alu_pkg::reg_view(dest_ent, s1_dest_q, s1_word_q);
    if (s1_src_imm_q) begin
      s_op = s1_word_q ? s1_imm_q : {8'h00, s1_imm_q[7:0]};
    end else begin
      s_op = x86alu_pkg::reg_view(src_ent, s1_src_q, s1_word_q);
    end

    is_add    = 1'b0;
    is_sub    = 1'b0;
    use_cin   = 1'b0;
    do_write  = 1'b0;
    flags_upd = 1'b0;
    r_res     = '0;
    unique case (s1_kind_q)
      x86alu_pkg::KIND_ADD: begin
        is_add = 1'b1; do_write = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_ADC: begin
        is_add = 1'b1; use_cin = 1'b1; do_write = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_SUB: begin
        is_sub = 1'b1; do_write = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_SBB: begin
        is_sub = 1'b1; use_cin = 1'b1; do_write = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_CMP: begin
        is_sub = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_OR: begin
        r_res = {1'b0, l_op | s_op}; do_write = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_AND: begin
        r_res = {1'b0, l_op & s_op}; do_write = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_XOR: begin
        r_res = {1'b0, l_op ^ s_op}; do_write = 1'b1; flags_upd = 1'b1;
      end
      x86alu_pkg::KIND_MOV: begin
        do_write = 1'b1;
      end
      // unused codes leave registers and flags alone
      default: begin
      end
    endcase

    cin      = use_cin && flags_q.cf;
    sum_res  = {1'b0, l_op} + {1'b0, s_op} + {{W{1'b0}}, cin};
    diff_res = {1'b0, l_op} - {1'b0, s_op} - {{W{1'b0}}, cin};
    if (is_add) begin
      r_res = sum_res;
    end else if (is_sub) begin
      r_res = diff_res;
    end

    t_res   = s1_word_q ? r_res[W-1:0] : {8'h00, r_res[7:0]};
    msb_sel = s1_word_q;
    x_bits  = l_op ^ s_op ^ r_res[W-1:0];
    of_add  = msb_sel ? ((l_op[15] ^ r_res[15]) & (s_op[15] ^ r_res[15]))
                      : ((l_op[7] ^ r_res[7]) & (s_op[7] ^ r_res[7]));
    of_sub  = msb_sel ? ((l_op[15] ^ s_op[15]) & (l_op[15] ^ r_res[15]))
                      : ((l_op[7] ^ s_op[7]) & (l_op[7] ^ r_res[7]));

    flags_d = flags_q;
    if (flags_upd) begin
      flags_d.cf   = s1_word_q ? r_res[16] : r_res[8];
      flags_d.pf   = ~^t_res[7:0];
      flags_d.zf   = (t_res == '0);
      flags_d.sf   = s1_word_q ? t_res[15] : t_res[7];
      flags_d.af   = (is_add || is_sub) && x_bits[4];
      flags_d.of_f = (is_add && of_add) || (is_sub && of_sub);
    end

    // destination value after the instruction
    if (s1_kind_q == x86alu_pkg::KIND_MOV) begin
      new_val = s_op;
    end else if (do_write) begin
      new_val = t_res;
    end else begin
      new_val = l_op;
    end
  end

  // write-back into the register file
  assign ram_we    = retire && do_write;
  assign ram_waddr = dest_idx;
  assign ram_wdata = x86alu_pkg::reg_merge(dest_ent, new_val, s1_dest_q, s1_word_q);

  always_comb begin
    s1_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ent_valid_q <= '0;
      wb_valid_q  <= 1'b0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        ent_valid_q[ram_waddr] <= 1'b1;
        wb_valid_q             <= 1'b1;
      end
      if (retire) begin
        flags_q <= flags_d;
      end
    end
  end

  // bypass payload
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wb_idx_q  <= ram_waddr;
      wb_data_q <= ram_wdata;
    end
  end

  // output register
  logic [W-1:0] old_q, new_q, flagw_q;

  always_ff @(posedge clk_i) begin
    if (retire) begin
      old_q   <= l_op;
      new_q   <= new_val;
      flagw_q <= x86alu_pkg::flags_to_word(flags_d);
    end
  end

  assign valid_o       = out_valid_q;
  assign dest_before_o = old_q;
  assign dest_after_o  = new_q;
  assign flag_word_o   = flagw_q;

endmodule

[rtl/x86alu_checker.sv]
// port-level checker for the x86 alu execute unit, bound to the top level
// depends on the assertion macros header
`include "x86_16bit_alu_register_execute_unit_defines.svh"

module x86alu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [15:0] dest_before_o,
  input logic [15:0] dest_after_o,
  input logic [15:0] flag_word_o
);

  // bits of the flags word outside the six defined flags
  localparam logic [15:0] UndefFlagMask = 16'hF72A;

  // whole result payload
  logic [47:0] rsp_payload;
  assign rsp_payload = {dest_before_o, dest_after_o, flag_word_o};

  // a held result keeps its payload
  `X86ALU_ASSERT(a_out_hold, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(rsp_payload))

  // only the six defined flags may be set
  `X86ALU_ASSERT_MSG(a_flag_bits, clk_i, rst_ni, valid_o |-> ((flag_word_o & UndefFlagMask) == '0), "x86alu: stray flag bit")

  // requests are held back only by a held result
  `X86ALU_ASSERT_MSG(a_stall_cause, clk_i, rst_ni, stall_o |-> (valid_o && stall_i), "x86alu: stray stall")

  // an accepted request reaches the output through the execute stage once the output drains
  `X86ALU_ASSERT(a_latency, clk_i, rst_ni, (valid_i && !stall_o) ##1 (!valid_o || !stall_i) |=> valid_o)

endmodule

bind x86_16bit_alu_register_execute_unit x86alu_checker u_x86alu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (valid_i),
  .stall_o       (stall_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .dest_before_o (dest_before_o),
  .dest_after_o  (dest_after_o),
  .flag_word_o   (flag_word_o)
);

[tb/sv/x86_16bit_alu_register_execute_unit_checker.sv]
// checker for the x86 alu execute unit: watches the request and result channels,
// keeps its own register file and flags, and compares each result in order
// depends on x86alu_pkg for the instruction kinds and the flag bit positions
module x86_16bit_alu_register_execute_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  logic [3:0]  kind_i,
  input  logic        word_size_i,
  input  logic [2:0]  dest_reg_i,
  input  logic        src_is_imm_i,
  input  logic [2:0]  src_reg_i,
  input  logic [15:0] immediate_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_stall_i,
  input  logic [15:0] dest_before_i,
  input  logic [15:0] dest_after_i,
  input  logic [15:0] flag_word_i,
  output int          mismatch_count_o,
  output int          in_flight_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] dest_before;
    logic [15:0] dest_after;
    logic [15:0] flag_word;
  } retired_t;

  // architectural state as the instruction stream leaves it
  logic [15:0] gpr [8];
  logic [15:0] eflags;
  retired_t    retire_q [$];
  int          mismatches;
  int          in_flight;

  assign mismatch_count_o = mismatches;
  assign in_flight_o      = in_flight;

  // operand view: whole word, or low/high byte of registers 0-3
  function automatic logic [15:0] read_gpr(logic [2:0] code, logic word);
    logic [15:0] ent;
    ent = word ? gpr[code] : gpr[{1'b0, code[1:0]}];
    if (word) begin
      return ent;
    end else if (code[2]) begin
      return {8'h00, ent[15:8]};
    end
    return {8'h00, ent[7:0]};
  endfunction

  task automatic write_gpr(input logic [2:0] code, input logic word, input logic [15:0] val);
    logic [1:0] idx;
    idx = code[1:0];
    if (word) begin
      gpr[code] = val;
    end else if (code[2]) begin
      gpr[idx] = {val[7:0], gpr[idx][7:0]};
    end else begin
      gpr[idx] = {gpr[idx][15:8], val[7:0]};
    end
  endtask

  // execute one instruction against the local state and queue its result
  task automatic retire_instr(input logic [3:0] kind, input logic word, input logic [2:0] dest,
                              input logic src_imm, input logic [2:0] src,
                              input logic [15:0] imm);
    logic [15:0] mask, lhs, rhs, trunc, newv, fl, ovf;
    logic [16:0] res, cin;
    logic        is_add, is_sub;
    retired_t    item;
    mask   = word ? 16'hFFFF : 16'h00FF;
    lhs    = read_gpr(dest, word);
    rhs    = src_imm ? (imm & mask) : read_gpr(src, word);
    cin    = {16'h0000, eflags[x86alu_pkg::FlagCfBit]};
    res    = '0;
    newv   = lhs;
    is_add = 1'b0;
    is_sub = 1'b0;
    case (kind)
      x86alu_pkg::KIND_ADD: begin
        res = {1'b0, lhs} + {1'b0, rhs};
        is_add = 1'b1;
      end
      x86alu_pkg::KIND_ADC: begin
        res = {1'b0, lhs} + {1'b0, rhs} + cin;
        is_add = 1'b1;
      end
      x86alu_pkg::KIND_SBB: begin
        res = {1'b0, lhs} - {1'b0, rhs} - cin;
        is_sub = 1'b1;
      end
      x86alu_pkg::KIND_SUB, x86alu_pkg::KIND_CMP: begin
        res = {1'b0, lhs} - {1'b0, rhs};
        is_sub = 1'b1;
      end
      x86alu_pkg::KIND_OR:  res = {1'b0, lhs | rhs};
      x86alu_pkg::KIND_AND: res = {1'b0, lhs & rhs};
      x86alu_pkg::KIND_XOR: res = {1'b0, lhs ^ rhs};
      x86alu_pkg::KIND_MOV: begin
        newv = rhs;
        write_gpr(dest, word, rhs);
      end
      default: ; // unused kinds leave everything alone
    endcase

    // flags for everything but mov and the unused kinds
    if (kind <= x86alu_pkg::KIND_CMP) begin
      trunc = res[15:0] & mask;
      fl    = '0;
      fl[x86alu_pkg::FlagCfBit] = word ? res[16] : res[8];
      fl[x86alu_pkg::FlagPfBit] = ~^trunc[7:0];
      fl[x86alu_pkg::FlagZfBit] = (trunc == 16'h0000);
      fl[x86alu_pkg::FlagSfBit] = word ? trunc[15] : trunc[7];
      if (is_add || is_sub) begin
        fl[x86alu_pkg::FlagAfBit] = lhs[4] ^ rhs[4] ^ res[4];
        ovf = is_add ? ((lhs ^ res[15:0]) & (rhs ^ res[15:0]))
                     : ((lhs ^ rhs) & (lhs ^ res[15:0]));
        fl[x86alu_pkg::FlagOfBit] = word ? ovf[15] : ovf[7];
      end
      eflags = fl;
      if (kind != x86alu_pkg::KIND_CMP) begin
        newv = trunc;
        write_gpr(dest, word, trunc);
      end
    end

    item.dest_before = lhs;
    item.dest_after  = newv;
    item.flag_word   = eflags;
    retire_q.push_back(item);
  endtask

  // accepted requests are modelled first, then accepted results are checked
  always @(posedge clk_i or negedge rst_ni) begin : watch
    retired_t head;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        gpr[i] = '0;
      end
      eflags = '0;
      retire_q.delete();
      mismatches = 0;
      in_flight  = 0;
    end else begin
      if (req_valid_i && !req_stall_i) begin
        retire_instr(kind_i, word_size_i, dest_reg_i, src_is_imm_i, src_reg_i, immediate_i);
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (retire_q.size() == 0) begin
          $error("result with no request outstanding: before %h after %h flags %h",
                 dest_before_i, dest_after_i, flag_word_i);
          mismatches++;
        end else begin
          head = retire_q.pop_front();
          if (dest_before_i !== head.dest_before) begin
            $error("dest_before: expected %h, got %h", head.dest_before, dest_before_i);
            mismatches++;
          end
          if (dest_after_i !== head.dest_after) begin
            $error("dest_after: expected %h, got %h", head.dest_after, dest_after_i);
            mismatches++;
          end
          if (flag_word_i !== head.flag_word) begin
            $error("flag_word: expected %h, got %h", head.flag_word, flag_word_i);
            mismatches++;
          end
        end
      end
      in_flight = retire_q.size();
    end
  end

endmodule

[tb/sv/x86_16bit_alu_register_execute_unit_tb.sv]
// top of the x86 alu execute unit testbench: clock, reset, request stimulus and
// result stalls over several idling phases; depends on x86alu_pkg, the unit and
// x86_16bit_alu_register_execute_unit_checker, which does all the comparing
module x86_16bit_alu_register_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] KindUnusedLo = 4'd9;
  localparam logic [3:0] KindUnusedHi = 4'd15;
  localparam int         RandomPerPhase = 160;
  localparam int         DrainCycles    = 8;
  localparam int         LimitCycles    = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [3:0]  kind_i;
  logic        word_size_i;
  logic [2:0]  dest_reg_i;
  logic        src_is_imm_i;
  logic [2:0]  src_reg_i;
  logic [15:0] immediate_i;
  logic        valid_o;
  logic        stall_i;
  logic [15:0] dest_before_o;
  logic [15:0] dest_after_o;
  logic [15:0] flag_word_o;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int in_flight;

  x86_16bit_alu_register_execute_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .kind_i       (kind_i),
    .word_size_i  (word_size_i),
    .dest_reg_i   (dest_reg_i),
    .src_is_imm_i (src_is_imm_i),
    .src_reg_i    (src_reg_i),
    .immediate_i  (immediate_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .dest_before_o(dest_before_o),
    .dest_after_o (dest_after_o),
    .flag_word_o  (flag_word_o)
  );

  x86_16bit_alu_register_execute_unit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (valid_i),
    .req_stall_i     (stall_o),
    .kind_i          (kind_i),
    .word_size_i     (word_size_i),
    .dest_reg_i      (dest_reg_i),
    .src_is_imm_i    (src_is_imm_i),
    .src_reg_i       (src_reg_i),
    .immediate_i     (immediate_i),
    .rsp_valid_i     (valid_o),
    .rsp_stall_i     (stall_i),
    .dest_before_i   (dest_before_o),
    .dest_after_i    (dest_after_o),
    .flag_word_i     (flag_word_o),
    .mismatch_count_o(mismatch_count),
    .in_flight_o     (in_flight)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side stalls at the rate of the current phase
  initial begin
    stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // hard stop if the run hangs
  initial begin
    #(LimitCycles * 12);
    $display("x86_16bit_alu_register_execute_unit test failed");
    $finish;
  end

  // one request: optional idle gap, then hold it until taken
  task automatic issue_instr(input logic [3:0] kind, input logic word, input logic [2:0] dest,
                             input logic src_imm, input logic [2:0] src,
                             input logic [15:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    kind_i       <= kind;
    word_size_i  <= word;
    dest_reg_i   <= dest;
    src_is_imm_i <= src_imm;
    src_reg_i    <= src;
    immediate_i  <= imm;
    do @(posedge clk_i); while (stall_o);
  endtask

  // random request, mostly valid kinds with a sprinkling of unused ones
  task automatic issue_random_instr();
    logic [3:0]  kind;
    logic [15:0] imm;
    if ($urandom_range(99) < 6) begin
      kind = 4'($urandom_range(KindUnusedHi, KindUnusedLo));
    end else begin
      kind = 4'($urandom_range(x86alu_pkg::KIND_MOV, x86alu_pkg::KIND_ADD));
    end
    case ($urandom_range(9))
      0:       imm = 16'h0000;
      1:       imm = 16'hFFFF;
      2:       imm = 16'h8000;
      3:       imm = 16'h7FFF;
      4:       imm = {8'($urandom), 8'h80};
      5:       imm = {8'($urandom), 8'h7F};
      default: imm = 16'($urandom);
    endcase
    issue_instr(kind, 1'($urandom), 3'($urandom), 1'($urandom), 3'($urandom), imm);
  endtask

  // stimulus and verdict
  initial begin
    rst_ni         <= 1'b0;
    valid_i        <= 1'b0;
    kind_i         <= x86alu_pkg::KIND_ADD;
    word_size_i    <= 1'b0;
    dest_reg_i     <= '0;
    src_is_imm_i   <= 1'b0;
    src_reg_i      <= '0;
    immediate_i    <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every kind, byte halves, compare, move, unused kinds
    issue_instr(x86alu_pkg::KIND_MOV, 1'b1, 3'd0, 1'b1, 3'd0, 16'hFFFF);
    issue_instr(x86alu_pkg::KIND_MOV, 1'b1, 3'd1, 1'b1, 3'd0, 16'h0001);
    issue_instr(x86alu_pkg::KIND_ADD, 1'b1, 3'd0, 1'b0, 3'd1, 16'h0000);
    issue_instr(x86alu_pkg::KIND_ADC, 1'b1, 3'd2, 1'b1, 3'd0, 16'h7FFF);
    issue_instr(x86alu_pkg::KIND_SBB, 1'b1, 3'd3, 1'b1, 3'd0, 16'hFFFF);
    issue_instr(x86alu_pkg::KIND_SBB, 1'b0, 3'd4, 1'b0, 3'd0, 16'h0000);
    issue_instr(x86alu_pkg::KIND_SUB, 1'b0, 3'd0, 1'b1, 3'd0, 16'h1280);
    issue_instr(x86alu_pkg::KIND_SUB, 1'b1, 3'd5, 1'b0, 3'd5, 16'h0000);
    issue_instr(x86alu_pkg::KIND_CMP, 1'b1, 3'd2, 1'b1, 3'd0, 16'h8000);
    issue_instr(x86alu_pkg::KIND_CMP, 1'b0, 3'd7, 1'b0, 3'd1, 16'h0000);
    issue_instr(x86alu_pkg::KIND_OR,  1'b1, 3'd6, 1'b1, 3'd0, 16'h0000);
    issue_instr(x86alu_pkg::KIND_OR,  1'b1, 3'd6, 1'b1, 3'd0, 16'h8000);
    issue_instr(x86alu_pkg::KIND_AND, 1'b1, 3'd2, 1'b0, 3'd0, 16'h0000);
    issue_instr(x86alu_pkg::KIND_AND, 1'b0, 3'd3, 1'b1, 3'd0, 16'h00FF);
    issue_instr(x86alu_pkg::KIND_XOR, 1'b1, 3'd0, 1'b0, 3'd0, 16'h0000);
    issue_instr(x86alu_pkg::KIND_XOR, 1'b0, 3'd6, 1'b1, 3'd0, 16'hFFAA);
    issue_instr(x86alu_pkg::KIND_MOV, 1'b0, 3'd7, 1'b1, 3'd0, 16'h12AB);
    issue_instr(x86alu_pkg::KIND_MOV, 1'b0, 3'd4, 1'b0, 3'd7, 16'h0000);
    issue_instr(x86alu_pkg::KIND_MOV, 1'b1, 3'd7, 1'b0, 3'd3, 16'h0000);
    issue_instr(x86alu_pkg::KIND_ADD, 1'b0, 3'd1, 1'b1, 3'd0, 16'h007F);
    issue_instr(x86alu_pkg::KIND_ADD, 1'b0, 3'd1, 1'b1, 3'd0, 16'h007F);
    issue_instr(x86alu_pkg::KIND_ADC, 1'b0, 3'd1, 1'b1, 3'd0, 16'h00FF);
    issue_instr(KindUnusedLo, 1'b1, 3'd2, 1'b0, 3'd6, 16'h0000);
    issue_instr(KindUnusedHi, 1'b0, 3'd5, 1'b1, 3'd0, 16'hFFFF);

    // random: no idling, sender idle, receiver stalling, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        issue_random_instr();
      end
    end
    valid_i <= 1'b0;

    // drain: let the last request reach the checker, then wait for its result
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && in_flight == 0) begin
      $display("x86_16bit_alu_register_execute_unit test passed");
    end else begin
      $display("x86_16bit_alu_register_execute_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/x86alu_pkg.sv
rtl/x86alu_ram.sv
rtl/x86_16bit_alu_register_execute_unit.sv
rtl/x86alu_checker.sv
tb/sv/x86_16bit_alu_register_execute_unit_checker.sv
tb/sv/x86_16bit_alu_register_execute_unit_tb.sv
